// ===== design/iicg_pkg.sv =====
// shared types and constants of the inverted index candidate gather block
`timescale 1ns / 1ps

package iicg_pkg;

    localparam int FUNC_W = 2;
    localparam int WORD_W = 10;
    localparam int DOC_W  = 12;
    localparam int SEG_W  = 6;
    localparam int MASK_W = 64;
    localparam int CFG_W  = 13;
    localparam int NUM_SEGS = 64;
    localparam int SEGS_W = 7;
    localparam logic [CFG_W-1:0] NUM_DOCS_RESET = 13'd4096;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_QUERY  = 2'd1,
        FN_FINISH = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_Q_RD,
        S_Q_WALK,
        S_FIN_RD,
        S_FIN_LD
    } t_state;

    typedef struct packed {
        logic load;
        logic len_rd;
        logic add_wr;
        logic walk_en;
        logic fin_rd;
        logic fin_load;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic walk_done;
        logic pipe_busy;
        logic fin_last;
        logic out_free;
        logic clr_last;
    } t_status;

endpackage

// ===== design/iicg_ctrl.sv =====
// controller state machine of the inverted index candidate gather block
`timescale 1ns / 1ps

module iicg_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic [iicg_pkg::FUNC_W-1:0] i_func,
    output logic                      o_stall,
    output iicg_pkg::t_cmd            o_cmd,
    input  iicg_pkg::t_status         i_status
);

    iicg_pkg::t_state r_state;
    iicg_pkg::t_state n_state;
    iicg_pkg::t_func  func;

    assign func = iicg_pkg::t_func'(i_func);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iicg_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        unique case (r_state)
            iicg_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = iicg_pkg::S_IDLE;
                end
            end
            iicg_pkg::S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (func)
                        iicg_pkg::FN_ADD:    n_state = iicg_pkg::S_ADD_RD;
                        iicg_pkg::FN_QUERY:  n_state = iicg_pkg::S_Q_RD;
                        iicg_pkg::FN_FINISH: n_state = iicg_pkg::S_FIN_RD;
                        iicg_pkg::FN_CLEAR:  n_state = iicg_pkg::S_CLEAR;
                        default:             n_state = iicg_pkg::S_IDLE;
                    endcase
                end
            end
            iicg_pkg::S_ADD_RD: begin
                o_cmd.len_rd = 1'b1;
                n_state = iicg_pkg::S_ADD_WR;
            end
            iicg_pkg::S_ADD_WR: begin
                o_cmd.add_wr = 1'b1;
                n_state = iicg_pkg::S_IDLE;
            end
            iicg_pkg::S_Q_RD: begin
                o_cmd.len_rd = 1'b1;
                n_state = iicg_pkg::S_Q_WALK;
            end
            iicg_pkg::S_Q_WALK: begin
                o_cmd.walk_en = 1'b1;
                if (i_status.walk_done && !i_status.pipe_busy) begin
                    n_state = iicg_pkg::S_IDLE;
                end
            end
            iicg_pkg::S_FIN_RD: begin
                o_cmd.fin_rd = 1'b1;
                n_state = iicg_pkg::S_FIN_LD;
            end
            iicg_pkg::S_FIN_LD: begin
                if (i_status.out_free) begin
                    o_cmd.fin_load = 1'b1;
                    n_state = i_status.fin_last ? iicg_pkg::S_IDLE : iicg_pkg::S_FIN_RD;
                end
            end
            default: begin
                n_state = iicg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== design/iicg_dp.sv =====
// datapath of the inverted index candidate gather block: index, lengths, hit map, output
`timescale 1ns / 1ps

module iicg_dp #(
    parameter int NUM_WORDS    = 1024,
    parameter int MAX_POSTINGS = 64,
    parameter int MAX_DOCS     = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [iicg_pkg::WORD_W-1:0] i_word_id,
    input  logic [iicg_pkg::DOC_W-1:0]  i_doc_id,
    input  logic                        i_cfg_valid,
    input  logic [iicg_pkg::CFG_W-1:0]  i_cfg_num_docs,
    input  iicg_pkg::t_cmd              i_cmd,
    output iicg_pkg::t_status           o_status,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [iicg_pkg::SEG_W-1:0]  o_segment_index,
    output logic [iicg_pkg::MASK_W-1:0] o_hit_mask,
    output logic                        o_last_segment
);

    localparam int WORD_SPACE = 1 << iicg_pkg::WORD_W;
    localparam int WORDS_USED = (NUM_WORDS > WORD_SPACE) ? WORD_SPACE : NUM_WORDS;
    localparam int WW = $clog2(WORDS_USED);
    localparam int PW = (MAX_POSTINGS > 1) ? $clog2(MAX_POSTINGS) : 1;
    localparam int LW = $clog2(MAX_POSTINGS + 1);
    localparam int AW = WW + PW;
    localparam int SEG_RAW = (MAX_DOCS + 63) / 64;
    localparam int SEG_LIMIT = (SEG_RAW > iicg_pkg::NUM_SEGS) ? iicg_pkg::NUM_SEGS : SEG_RAW;
    localparam int DOC_LIMIT = (MAX_DOCS < SEG_LIMIT * 64) ? MAX_DOCS : SEG_LIMIT * 64;

    logic [LW-1:0]               mem_len [WORDS_USED];
    logic [iicg_pkg::DOC_W-1:0]  mem_post [WORDS_USED << PW];
    logic [iicg_pkg::MASK_W-1:0] mem_bm [iicg_pkg::NUM_SEGS];

    logic [iicg_pkg::CFG_W-1:0]  r_num_docs;
    logic [iicg_pkg::WORD_W-1:0] r_word;
    logic [iicg_pkg::DOC_W-1:0]  r_doc;
    logic                        r_word_ok;
    logic [LW-1:0]               r_len_q;
    logic [LW-1:0]               r_j;
    logic [WW-1:0]               r_clr_addr;
    logic [iicg_pkg::SEG_W-1:0]  r_seg;

    logic                        r_p1_vld;
    logic [iicg_pkg::DOC_W-1:0]  r_post_q;
    logic                        r_p2_vld;
    logic [iicg_pkg::SEG_W-1:0]  r_p2_seg;
    logic [iicg_pkg::SEG_W-1:0]  r_p2_bit;
    logic [iicg_pkg::MASK_W-1:0] r_bm_q;
    logic                        r_bm_rvld;
    logic [iicg_pkg::NUM_SEGS-1:0] r_bm_vld;
    logic                        r_fw_vld;
    logic [iicg_pkg::SEG_W-1:0]  r_fw_seg;
    logic [iicg_pkg::MASK_W-1:0] r_fw_data;

    logic                        r_out_vld;
    logic [iicg_pkg::SEG_W-1:0]  r_out_seg;
    logic [iicg_pkg::MASK_W-1:0] r_out_mask;
    logic                        r_out_last;

    logic [WW-1:0]               widx;
    logic [LW-1:0]               eff_len;
    logic                        len_ok;
    logic [iicg_pkg::CFG_W-1:0]  lim;
    logic [iicg_pkg::SEGS_W-1:0] segs;
    logic                        walk_issue;
    logic                        p1_hit;
    logic                        bm_rd;
    logic [iicg_pkg::SEG_W-1:0]  bm_rd_addr;
    logic [iicg_pkg::MASK_W-1:0] p2_old;
    logic [iicg_pkg::MASK_W-1:0] p2_new;
    logic                        fin_last;

    assign widx    = r_word[WW-1:0];
    assign eff_len = r_word_ok ? r_len_q : '0;
    assign len_ok  = r_len_q < LW'(MAX_POSTINGS);

    assign lim    = (r_num_docs > iicg_pkg::CFG_W'(DOC_LIMIT)) ?
                    iicg_pkg::CFG_W'(DOC_LIMIT) : r_num_docs;
    always_comb begin
        segs = lim[iicg_pkg::CFG_W-1:iicg_pkg::CFG_W-iicg_pkg::SEGS_W]
               + iicg_pkg::SEGS_W'(|lim[iicg_pkg::CFG_W-iicg_pkg::SEGS_W-1:0]);
        if (segs == '0) begin
            segs = iicg_pkg::SEGS_W'(1);
        end
    end
    assign fin_last = ({1'b0, r_seg} + iicg_pkg::SEGS_W'(1)) == segs;

    assign walk_issue = i_cmd.walk_en && (r_j < eff_len);
    assign p1_hit     = r_p1_vld && ({1'b0, r_post_q} < lim);
    assign bm_rd      = i_cmd.fin_rd || p1_hit;
    assign bm_rd_addr = i_cmd.fin_rd ? r_seg : r_post_q[iicg_pkg::DOC_W-1:iicg_pkg::DOC_W-iicg_pkg::SEG_W];

    // newest copy of the row comes from the write made in the cycle before
    always_comb begin
        if (r_fw_vld && (r_fw_seg == r_p2_seg)) begin
            p2_old = r_fw_data;
        end else if (r_bm_rvld) begin
            p2_old = r_bm_q;
        end else begin
            p2_old = '0;
        end
        p2_new = p2_old | (iicg_pkg::MASK_W'(1) << r_p2_bit);
    end

    // item fields and config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_docs <= iicg_pkg::NUM_DOCS_RESET;
        end else if (i_cfg_valid) begin
            r_num_docs <= i_cfg_num_docs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word    <= i_word_id;
            r_doc     <= i_doc_id;
            r_word_ok <= 32'(i_word_id) < NUM_WORDS;
        end
    end

    // list lengths
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            mem_len[r_clr_addr] <= '0;
        end else if (i_cmd.add_wr && r_word_ok && len_ok) begin
            mem_len[widx] <= r_len_q + LW'(1);
        end
        if (i_cmd.len_rd) begin
            r_len_q <= mem_len[widx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= o_status.clr_last ? '0 : r_clr_addr + WW'(1);
        end
    end

    // posting store
    always_ff @(posedge i_clk) begin
        if (i_cmd.add_wr && r_word_ok && len_ok) begin
            mem_post[AW'({widx, r_len_q[PW-1:0]})] <= r_doc;
        end
        if (walk_issue) begin
            r_post_q <= mem_post[AW'({widx, r_j[PW-1:0]})];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_j <= '0;
        end else if (walk_issue) begin
            r_j <= r_j + LW'(1);
        end
    end

    // hit map
    always_ff @(posedge i_clk) begin
        if (r_p2_vld) begin
            mem_bm[r_p2_seg] <= p2_new;
        end
        if (bm_rd) begin
            r_bm_q    <= mem_bm[bm_rd_addr];
            r_bm_rvld <= r_bm_vld[bm_rd_addr];
        end
        if (p1_hit) begin
            r_p2_seg <= r_post_q[iicg_pkg::DOC_W-1:iicg_pkg::DOC_W-iicg_pkg::SEG_W];
            r_p2_bit <= r_post_q[iicg_pkg::SEG_W-1:0];
        end
        if (r_p2_vld) begin
            r_fw_seg  <= r_p2_seg;
            r_fw_data <= p2_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_fw_vld <= 1'b0;
            r_bm_vld <= '0;
        end else begin
            r_p1_vld <= walk_issue;
            r_p2_vld <= p1_hit;
            r_fw_vld <= r_p2_vld;
            if (i_cmd.fin_load && fin_last) begin
                r_bm_vld <= '0;
            end else if (r_p2_vld) begin
                r_bm_vld[r_p2_seg] <= 1'b1;
            end
        end
    end

    // segment counter and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_seg <= '0;
        end else if (i_cmd.fin_load) begin
            r_seg <= r_seg + iicg_pkg::SEG_W'(1);
        end
        if (i_cmd.fin_load) begin
            r_out_seg  <= r_seg;
            r_out_mask <= r_bm_rvld ? r_bm_q : '0;
            r_out_last <= fin_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.fin_load) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_status.walk_done = r_j >= eff_len;
    assign o_status.pipe_busy = r_p1_vld || r_p2_vld;
    assign o_status.fin_last  = fin_last;
    assign o_status.out_free  = !r_out_vld || !i_stall;
    assign o_status.clr_last  = r_clr_addr == WW'(WORDS_USED - 1);

    assign o_valid         = r_out_vld;
    assign o_segment_index = r_out_seg;
    assign o_hit_mask      = r_out_mask;
    assign o_last_segment  = r_out_last;

endmodule

// ===== design/inverted_index_candidate_gather.sv =====
// top level of the inverted index candidate gather block
//
//  channel  direction  handshake                 payload
//  input    in         i_valid / o_stall         i_func, i_word_id, i_doc_id
//  output   out        o_valid / i_stall         o_segment_index, o_hit_mask, o_last_segment
//  config   in         i_cfg_valid / o_cfg_ready i_cfg_num_docs
//
// add posting reads the list length, then appends; clear index zeroes one length entry a cycle
// query reads one posting store entry a cycle, then does a hit map read-modify-write
// finish reads the hit map and loads the output for each segment, held while the output is stalled
// after reset a sweep zeroes the list lengths; no item is taken meanwhile
// the last segment may wait in the output register while the next item is taken
`timescale 1ns / 1ps

module inverted_index_candidate_gather #(
    parameter int NUM_WORDS    = 1024,
    parameter int MAX_POSTINGS = 64,
    parameter int MAX_DOCS     = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [iicg_pkg::FUNC_W-1:0] i_func,
    input  logic [iicg_pkg::WORD_W-1:0] i_word_id,
    input  logic [iicg_pkg::DOC_W-1:0]  i_doc_id,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [iicg_pkg::SEG_W-1:0]  o_segment_index,
    output logic [iicg_pkg::MASK_W-1:0] o_hit_mask,
    output logic                        o_last_segment,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [iicg_pkg::CFG_W-1:0]  i_cfg_num_docs
);

    iicg_pkg::t_cmd    cmd;
    iicg_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    iicg_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .o_stall  (o_stall),
        .o_cmd    (cmd),
        .i_status (status)
    );

    iicg_dp #(
        .NUM_WORDS    (NUM_WORDS),
        .MAX_POSTINGS (MAX_POSTINGS),
        .MAX_DOCS     (MAX_DOCS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_word_id       (i_word_id),
        .i_doc_id        (i_doc_id),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_num_docs  (i_cfg_num_docs),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_segment_index (o_segment_index),
        .o_hit_mask      (o_hit_mask),
        .o_last_segment  (o_last_segment)
    );

`ifndef ASSERT_OFF
    // a segment that is not the last one means the finish run is still going
    a_fin_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_segment |-> o_stall)
        else $error("non-final segment pending while block takes items");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.fin_load |-> status.out_free)
        else $error("output register overwritten while stalled");

    a_add_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.add_wr |-> $past(cmd.len_rd))
        else $error("posting append without length read");

    a_pipe_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |-> !status.pipe_busy)
        else $error("item taken while query pipeline busy");
`endif

endmodule

// ===== tb/sv/candidate_gather_checker.sv =====
// checker that predicts and compares the hit segments of the candidate gather block
`timescale 1ns / 1ps

module candidate_gather_checker #(
    parameter int NUM_WORDS    = 1024,
    parameter int MAX_POSTINGS = 64,
    parameter int MAX_DOCS     = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic                        i_in_stall,
    input  logic [iicg_pkg::FUNC_W-1:0] i_func,
    input  logic [iicg_pkg::WORD_W-1:0] i_word_id,
    input  logic [iicg_pkg::DOC_W-1:0]  i_doc_id,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic [iicg_pkg::SEG_W-1:0]  i_segment_index,
    input  logic [iicg_pkg::MASK_W-1:0] i_hit_mask,
    input  logic                        i_last_segment,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [iicg_pkg::CFG_W-1:0]  i_cfg_num_docs,
    output int                          o_fail_count,
    output int                          o_pending
);

    typedef struct packed {
        logic [iicg_pkg::SEG_W-1:0]  seg;
        logic [iicg_pkg::MASK_W-1:0] mask;
        logic                        last;
    } t_segment;

    logic [iicg_pkg::DOC_W-1:0]  postings [NUM_WORDS][MAX_POSTINGS];
    int unsigned                 list_len [NUM_WORDS];
    logic [iicg_pkg::MASK_W-1:0] hit_map [iicg_pkg::NUM_SEGS];
    logic [iicg_pkg::CFG_W-1:0]  doc_count;
    t_segment                    pending_segments [$];
    int                          fails = 0;

    task automatic gather_item(input iicg_pkg::t_func f,
                               input logic [iicg_pkg::WORD_W-1:0] w,
                               input logic [iicg_pkg::DOC_W-1:0] d);
        int unsigned lim;
        int unsigned nseg;
        int unsigned p;
        t_segment    s;
        lim = doc_count;
        if (lim > MAX_DOCS) lim = MAX_DOCS;
        if (lim > iicg_pkg::NUM_SEGS * 64) lim = iicg_pkg::NUM_SEGS * 64;
        case (f)
            iicg_pkg::FN_ADD: begin
                if (w < NUM_WORDS && list_len[w] < MAX_POSTINGS) begin
                    postings[w][list_len[w]] = d;
                    list_len[w]++;
                end
            end
            iicg_pkg::FN_QUERY: begin
                if (w < NUM_WORDS) begin
                    for (int j = 0; j < list_len[w]; j++) begin
                        p = postings[w][j];
                        if (p < lim) hit_map[p / 64][p % 64] = 1'b1;
                    end
                end
            end
            iicg_pkg::FN_FINISH: begin
                nseg = (lim + 63) / 64;
                if (nseg == 0) nseg = 1;
                for (int k = 0; k < nseg; k++) begin
                    s.seg  = k[iicg_pkg::SEG_W-1:0];
                    s.mask = hit_map[k];
                    s.last = (k + 1 == nseg);
                    pending_segments.push_back(s);
                end
                for (int k = 0; k < iicg_pkg::NUM_SEGS; k++) hit_map[k] = '0;
            end
            iicg_pkg::FN_CLEAR: begin
                for (int k = 0; k < NUM_WORDS; k++) list_len[k] = 0;
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin : watch
        t_segment got;
        t_segment want;
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_WORDS; k++) list_len[k] = 0;
            for (int k = 0; k < iicg_pkg::NUM_SEGS; k++) hit_map[k] = '0;
            doc_count = iicg_pkg::NUM_DOCS_RESET;
            pending_segments.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) doc_count = i_cfg_num_docs;
            if (i_out_valid && !i_out_stall) begin
                got.seg  = i_segment_index;
                got.mask = i_hit_mask;
                got.last = i_last_segment;
                if (pending_segments.size() == 0) begin
                    fails++;
                    $display("%0t: segment %0d with no item pending, mask %h last %b",
                             $time, got.seg, got.mask, got.last);
                end else begin
                    want = pending_segments.pop_front();
                    if (got.seg !== want.seg) begin
                        fails++;
                        $display("%0t: segment_index expected %0d actual %0d",
                                 $time, want.seg, got.seg);
                    end
                    if (got.mask !== want.mask) begin
                        fails++;
                        $display("%0t: hit_mask expected %h actual %h",
                                 $time, want.mask, got.mask);
                    end
                    if (got.last !== want.last) begin
                        fails++;
                        $display("%0t: last_segment expected %b actual %b",
                                 $time, want.last, got.last);
                    end
                end
            end
            if (i_valid && !i_in_stall) begin
                gather_item(iicg_pkg::t_func'(i_func), i_word_id, i_doc_id);
            end
        end
        o_fail_count <= fails;
        o_pending    <= pending_segments.size();
    end

endmodule

// ===== tb/sv/inverted_index_candidate_gather_tb.sv =====
// testbench top that drives the candidate gather block and gives the verdict
`timescale 1ns / 1ps

module inverted_index_candidate_gather_tb;

    localparam int NUM_WORDS     = 1024;
    localparam int MAX_POSTINGS  = 64;
    localparam int MAX_DOCS      = 4096;
    localparam int CLK_HALF      = 6;
    localparam int SETTLE_CYCLES = 1200;
    localparam int LONG_HOLD     = 600;
    localparam int LIMIT_NS      = 40_000_000;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [iicg_pkg::FUNC_W-1:0]   i_func = '0;
    logic [iicg_pkg::WORD_W-1:0]   i_word_id = '0;
    logic [iicg_pkg::DOC_W-1:0]    i_doc_id = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic [iicg_pkg::SEG_W-1:0]    o_segment_index;
    logic [iicg_pkg::MASK_W-1:0]   o_hit_mask;
    logic                          o_last_segment;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [iicg_pkg::CFG_W-1:0]    i_cfg_num_docs = iicg_pkg::NUM_DOCS_RESET;

    int          fail_count;
    int          pending;
    int unsigned cur_docs = 4096;
    bit          tx_calm = 1'b0;

    inverted_index_candidate_gather #(
        .NUM_WORDS    (NUM_WORDS),
        .MAX_POSTINGS (MAX_POSTINGS),
        .MAX_DOCS     (MAX_DOCS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_func          (i_func),
        .i_word_id       (i_word_id),
        .i_doc_id        (i_doc_id),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_segment_index (o_segment_index),
        .o_hit_mask      (o_hit_mask),
        .o_last_segment  (o_last_segment),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_num_docs  (i_cfg_num_docs)
    );

    candidate_gather_checker #(
        .NUM_WORDS    (NUM_WORDS),
        .MAX_POSTINGS (MAX_POSTINGS),
        .MAX_DOCS     (MAX_DOCS)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_in_stall      (o_stall),
        .i_func          (i_func),
        .i_word_id       (i_word_id),
        .i_doc_id        (i_doc_id),
        .i_out_valid     (o_valid),
        .i_out_stall     (i_stall),
        .i_segment_index (o_segment_index),
        .i_hit_mask      (o_hit_mask),
        .i_last_segment  (o_last_segment),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_num_docs  (i_cfg_num_docs),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin : run_limit
        #(LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    // output side: random stall after each item, one long hold to back the block up
    initial begin : segment_sink
        int unsigned taken;
        int unsigned hold;
        bit          calm;
        taken = 0;
        hold  = 0;
        calm  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid === 1'b1 && !i_stall) begin
                taken++;
                if ($urandom_range(0, 19) == 0) calm = !calm;
                hold = calm ? 0 : $urandom_range(0, 13);
                if (taken == 70) hold = LONG_HOLD;
            end
            @(negedge i_clk);
            i_stall <= (hold > 0);
            if (hold > 0) hold--;
        end
    end

    function automatic logic [iicg_pkg::DOC_W-1:0] pick_doc();
        int unsigned lim;
        lim = (cur_docs > MAX_DOCS) ? MAX_DOCS : cur_docs;
        if (lim == 0 || $urandom_range(0, 1) == 0) begin
            return iicg_pkg::DOC_W'($urandom_range(0, 4095));
        end
        return iicg_pkg::DOC_W'($urandom_range(0, lim - 1));
    endfunction

    function automatic logic [iicg_pkg::WORD_W-1:0] any_word();
        return iicg_pkg::WORD_W'($urandom_range(0, 1023));
    endfunction

    function automatic logic [iicg_pkg::DOC_W-1:0] any_doc();
        return iicg_pkg::DOC_W'($urandom_range(0, 4095));
    endfunction

    task automatic put_item(input iicg_pkg::t_func f,
                            input logic [iicg_pkg::WORD_W-1:0] w,
                            input logic [iicg_pkg::DOC_W-1:0] d);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 13);
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_func    <= f;
        i_word_id <= w;
        i_doc_id  <= d;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_doc_count(input int unsigned v);
        settle();
        @(negedge i_clk);
        i_cfg_valid    <= 1'b1;
        i_cfg_num_docs <= v[iicg_pkg::CFG_W-1:0];
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_docs = v;
    endtask

    // mostly fill, query and finish runs over a few hot words, some noise
    task automatic run_phase(input int unsigned budget);
        logic [iicg_pkg::WORD_W-1:0] pool [3];
        logic [iicg_pkg::WORD_W-1:0] w;
        int unsigned                 sent;
        int unsigned                 n;
        iicg_pkg::t_func             f;
        for (int k = 0; k < 3; k++) pool[k] = any_word();
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    n = $urandom_range(4, 16);
                    repeat (n) put_item(iicg_pkg::FN_ADD, pool[$urandom_range(0, 2)], pick_doc());
                    sent += n;
                end
                5, 6, 7: begin
                    n = $urandom_range(1, 3);
                    repeat (n) begin
                        w = ($urandom_range(0, 4) == 0) ? any_word()
                                                        : pool[$urandom_range(0, 2)];
                        put_item(iicg_pkg::FN_QUERY, w, any_doc());
                    end
                    put_item(iicg_pkg::FN_FINISH, any_word(), any_doc());
                    sent += n + 1;
                end
                default: begin
                    f = iicg_pkg::t_func'($urandom_range(0, 3));
                    if (f == iicg_pkg::FN_CLEAR && $urandom_range(0, 3) != 0) begin
                        f = iicg_pkg::FN_QUERY;
                    end
                    put_item(f, any_word(), any_doc());
                    sent++;
                end
            endcase
        end
    endtask

    initial begin : stimulus
        int unsigned                 doc_settings [5];
        logic [iicg_pkg::WORD_W-1:0] deep_word;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty map, extreme word and document ids, duplicate hit, empty list
        put_item(iicg_pkg::FN_FINISH, 10'h3FF, 12'hFFF);
        put_item(iicg_pkg::FN_ADD, 10'd0, 12'd0);
        put_item(iicg_pkg::FN_ADD, 10'd0, 12'd4095);
        put_item(iicg_pkg::FN_ADD, 10'd1023, 12'hAAA);
        put_item(iicg_pkg::FN_ADD, 10'd1023, 12'h555);
        put_item(iicg_pkg::FN_ADD, 10'h2AA, 12'd63);
        put_item(iicg_pkg::FN_ADD, 10'h155, 12'd64);
        put_item(iicg_pkg::FN_ADD, 10'd0, 12'd0);
        put_item(iicg_pkg::FN_QUERY, 10'd0, 12'd0);
        put_item(iicg_pkg::FN_QUERY, 10'd1023, 12'hFFF);
        put_item(iicg_pkg::FN_QUERY, 10'h2AA, 12'd0);
        put_item(iicg_pkg::FN_QUERY, 10'h155, 12'd0);
        put_item(iicg_pkg::FN_QUERY, 10'd7, 12'd0);
        put_item(iicg_pkg::FN_FINISH, 10'd0, 12'd0);
        // clear keeps the map but empties every list
        put_item(iicg_pkg::FN_QUERY, 10'd0, 12'd0);
        put_item(iicg_pkg::FN_CLEAR, 10'd0, 12'd0);
        put_item(iicg_pkg::FN_QUERY, 10'd0, 12'd0);
        put_item(iicg_pkg::FN_FINISH, 10'd0, 12'd0);

        set_doc_count(1);
        put_item(iicg_pkg::FN_ADD, 10'd5, 12'd0);
        put_item(iicg_pkg::FN_ADD, 10'd5, 12'd1);
        put_item(iicg_pkg::FN_QUERY, 10'd5, 12'd0);
        put_item(iicg_pkg::FN_FINISH, 10'd0, 12'd0);

        set_doc_count(0);
        put_item(iicg_pkg::FN_QUERY, 10'd5, 12'd0);
        put_item(iicg_pkg::FN_FINISH, 10'd0, 12'd0);

        doc_settings[0] = 8191;
        doc_settings[1] = 65;
        doc_settings[2] = 64;
        doc_settings[3] = $urandom_range(1, 4096);
        doc_settings[4] = 4096;
        for (int ph = 0; ph < 5; ph++) begin
            set_doc_count(doc_settings[ph]);
            if (ph == 1) begin
                // overfill one list so the tail of the adds is dropped
                deep_word = any_word();
                repeat (70) put_item(iicg_pkg::FN_ADD, deep_word, pick_doc());
                put_item(iicg_pkg::FN_QUERY, deep_word, 12'd0);
                put_item(iicg_pkg::FN_FINISH, 10'd0, 12'd0);
            end
            run_phase(12);
        end

        settle();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/iicg_pkg.sv
design/iicg_ctrl.sv
design/iicg_dp.sv
design/inverted_index_candidate_gather.sv
tb/sv/candidate_gather_checker.sv
tb/sv/inverted_index_candidate_gather_tb.sv
